[rtl/lesf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// lesf_pkg: shared types and constants of the largest empty square finder
// Sizes of the grid, widths of the fields, register indexes and the format of
// a classified cell as it travels from the front part to the back part.
// ============================================================================
package lesf_pkg;

    localparam int MAX_COLS    = 1024;
    localparam int MAX_ROWS    = 1024;
    localparam int COL_W       = $clog2(MAX_COLS);
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int COUNT_W     = 11;
    localparam int SIZE_W      = 11;
    localparam int CHAR_W      = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 11;

    // Queue depth must be a power of two so the pointers wrap naturally.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [SIZE_W-1:0]  SIZE_LIMIT      = '1;
    localparam logic [COUNT_W-1:0] ROW_COUNT_RST   = COUNT_W'(1);
    localparam logic [COUNT_W-1:0] COL_COUNT_RST   = COUNT_W'(1);
    localparam logic [CHAR_W-1:0]  EMPTY_CHAR_RST  = CHAR_W'(46);
    localparam logic [CHAR_W-1:0]  OBST_CHAR_RST   = CHAR_W'(111);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_COUNT,
        REG_COLUMN_COUNT,
        REG_EMPTY_CHAR,
        REG_OBSTACLE_CHAR
    } cfg_reg_t;

    typedef enum logic [1:0] {
        CELL_EMPTY,
        CELL_OBSTACLE,
        CELL_BAD
    } cell_kind_t;

    typedef struct packed {
        cell_kind_t       kind;
        logic             edge_cell;   // first row or first column
        logic             frame_end;   // last cell of the frame
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } cell_item_t;

    // A count of zero acts as one, a count above the maximum acts as the maximum.
    function automatic logic [COUNT_W-1:0] clamp_count(
        input logic [COUNT_W-1:0] v,
        input logic [COUNT_W-1:0] maxv
    );
        logic [COUNT_W-1:0] r;
        if (v == '0)
            r = COUNT_W'(1);
        else if (v > maxv)
            r = maxv;
        else
            r = v;
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/lesf_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// lesf_front: configuration registers, cell classification and raster counters
// Accepts one cell per cycle while the queue has room, tags it with its
// position, its class and the end-of-frame mark, and pushes it to the queue.
// ============================================================================
module lesf_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic [lesf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lesf_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                          cell_valid,
    input  wire logic [lesf_pkg::CHAR_W-1:0]   cell_char,
    output logic                               cell_stall,
    input  wire logic                          queue_full,
    output logic                               push,
    output lesf_pkg::cell_item_t               push_item
);

    logic [lesf_pkg::COUNT_W-1:0] row_count_reg;
    logic [lesf_pkg::COUNT_W-1:0] column_count_reg;
    logic [lesf_pkg::CHAR_W-1:0]  empty_char_reg;
    logic [lesf_pkg::CHAR_W-1:0]  obstacle_char_reg;

    logic [lesf_pkg::ROW_W-1:0]   row_reg;
    logic [lesf_pkg::ROW_W-1:0]   row_next;
    logic [lesf_pkg::COL_W-1:0]   col_reg;
    logic [lesf_pkg::COL_W-1:0]   col_next;

    logic [lesf_pkg::COUNT_W-1:0] rows;
    logic [lesf_pkg::COUNT_W-1:0] cols;
    logic                         row_end;
    logic                         last_row;
    lesf_pkg::cell_kind_t         kind;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg     <= lesf_pkg::ROW_COUNT_RST;
            column_count_reg  <= lesf_pkg::COL_COUNT_RST;
            empty_char_reg    <= lesf_pkg::EMPTY_CHAR_RST;
            obstacle_char_reg <= lesf_pkg::OBST_CHAR_RST;
        end
        else if (cfg_write)
        begin
            case (lesf_pkg::cfg_reg_t'(cfg_index))
                lesf_pkg::REG_ROW_COUNT:     row_count_reg     <= cfg_data;
                lesf_pkg::REG_COLUMN_COUNT:  column_count_reg  <= cfg_data;
                lesf_pkg::REG_EMPTY_CHAR:    empty_char_reg    <= cfg_data[lesf_pkg::CHAR_W-1:0];
                lesf_pkg::REG_OBSTACLE_CHAR: obstacle_char_reg <= cfg_data[lesf_pkg::CHAR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        rows     = lesf_pkg::clamp_count(row_count_reg,
                                         lesf_pkg::COUNT_W'(lesf_pkg::MAX_ROWS));
        cols     = lesf_pkg::clamp_count(column_count_reg,
                                         lesf_pkg::COUNT_W'(lesf_pkg::MAX_COLS));
        row_end  = (lesf_pkg::COUNT_W'(col_reg) + lesf_pkg::COUNT_W'(1)) >= cols;
        last_row = (lesf_pkg::COUNT_W'(row_reg) + lesf_pkg::COUNT_W'(1)) >= rows;

        // An obstacle match wins, so equal codes classify as obstacle.
        if (cell_char == obstacle_char_reg)
            kind = lesf_pkg::CELL_OBSTACLE;
        else if (cell_char == empty_char_reg)
            kind = lesf_pkg::CELL_EMPTY;
        else
            kind = lesf_pkg::CELL_BAD;
    end

    assign cell_stall = queue_full;
    assign push       = cell_valid && !queue_full;

    always_comb
    begin
        push_item.kind      = kind;
        push_item.edge_cell = (row_reg == '0) || (col_reg == '0);
        push_item.frame_end = row_end && last_row;
        push_item.row       = row_reg;
        push_item.col       = col_reg;
    end

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (push)
        begin
            if (!row_end)
                col_next = col_reg + lesf_pkg::COL_W'(1);
            else
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + lesf_pkg::ROW_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

endmodule
`default_nettype wire

[rtl/lesf_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// lesf_queue: small register queue of classified cells
// Decouples the front part from the back part; a push and a pop may happen
// in the same cycle.
// ============================================================================
module lesf_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire lesf_pkg::cell_item_t  push_item,
    output logic                       full,
    input  wire logic                  pop,
    output logic                       head_valid,
    output lesf_pkg::cell_item_t       head_item
);

    lesf_pkg::cell_item_t           slots [lesf_pkg::QUEUE_DEPTH];
    logic [lesf_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [lesf_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [lesf_pkg::QPTR_W:0]      count_reg;
    logic [lesf_pkg::QPTR_W:0]      count_next;

    assign full       = (count_reg == (lesf_pkg::QPTR_W+1)'(lesf_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = slots[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + (lesf_pkg::QPTR_W+1)'(1);
        else if (pop && !push)
            count_next = count_reg - (lesf_pkg::QPTR_W+1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + lesf_pkg::QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + lesf_pkg::QPTR_W'(1);
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

[rtl/lesf_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// lesf_back: square-size recurrence, line buffer and best-square tracking
// Pops a cell and reads the line buffer at its column in the same cycle; from
// the work register it computes the side, writes it back and updates the best
// square. The frame result waits in an output register.
// ============================================================================
module lesf_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         head_valid,
    input  wire lesf_pkg::cell_item_t         head_item,
    output logic                              pop,
    output logic                              result_valid,
    input  wire logic                         result_stall,
    output logic [lesf_pkg::SIZE_W-1:0]       square_size,
    output logic [lesf_pkg::ROW_W-1:0]        bottom_row,
    output logic [lesf_pkg::COL_W-1:0]        right_col,
    output logic                              bad_cell
);

    logic [lesf_pkg::SIZE_W-1:0] line_buf [lesf_pkg::MAX_COLS];

    logic                        work_valid_reg;
    logic                        work_valid_next;
    lesf_pkg::cell_item_t        work_item_reg;
    logic [lesf_pkg::SIZE_W-1:0] up_rd_reg;
    logic                        fwd_hit_reg;
    logic [lesf_pkg::SIZE_W-1:0] fwd_val_reg;
    logic [lesf_pkg::SIZE_W-1:0] left_reg;
    logic [lesf_pkg::SIZE_W-1:0] diag_reg;

    logic [lesf_pkg::SIZE_W-1:0] best_size_reg;
    logic [lesf_pkg::SIZE_W-1:0] best_size_next;
    logic [lesf_pkg::ROW_W-1:0]  best_row_reg;
    logic [lesf_pkg::ROW_W-1:0]  best_row_next;
    logic [lesf_pkg::COL_W-1:0]  best_col_reg;
    logic [lesf_pkg::COL_W-1:0]  best_col_next;
    logic                        bad_seen_reg;
    logic                        bad_seen_next;

    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [lesf_pkg::SIZE_W-1:0] out_size_reg;
    logic [lesf_pkg::ROW_W-1:0]  out_row_reg;
    logic [lesf_pkg::COL_W-1:0]  out_col_reg;
    logic                        out_bad_reg;

    logic                        out_free;
    logic                        work_go;
    logic [lesf_pkg::SIZE_W-1:0] up;
    logic [lesf_pkg::SIZE_W-1:0] min_ul;
    logic [lesf_pkg::SIZE_W-1:0] min_all;
    logic [lesf_pkg::SIZE_W:0]   grown;
    logic [lesf_pkg::SIZE_W-1:0] side;
    logic                        is_bad;
    logic                        better;

    assign out_free = !out_valid_reg || !result_stall;
    assign work_go  = work_valid_reg && (!work_item_reg.frame_end || out_free);
    assign pop      = head_valid && (!work_valid_reg || work_go);

    // The column just read may be the one being written back this cycle
    // (single-column grids); the forwarded side then replaces the stale read.
    assign up = fwd_hit_reg ? fwd_val_reg : up_rd_reg;

    always_comb
    begin
        min_ul  = (up < left_reg) ? up : left_reg;
        min_all = (min_ul < diag_reg) ? min_ul : diag_reg;
        grown   = {1'b0, min_all} + (lesf_pkg::SIZE_W+1)'(1);
        is_bad  = (work_item_reg.kind == lesf_pkg::CELL_BAD);
        case (work_item_reg.kind)
            lesf_pkg::CELL_EMPTY:
            begin
                if (work_item_reg.edge_cell)
                    side = lesf_pkg::SIZE_W'(1);
                else if (grown > (lesf_pkg::SIZE_W+1)'(lesf_pkg::SIZE_LIMIT))
                    side = lesf_pkg::SIZE_LIMIT;
                else
                    side = grown[lesf_pkg::SIZE_W-1:0];
            end
            default: side = '0;
        endcase
        better = side > best_size_reg;
    end

    always_comb
    begin
        work_valid_next = work_valid_reg;
        if (pop)
            work_valid_next = 1'b1;
        else if (work_go)
            work_valid_next = 1'b0;

        best_size_next = best_size_reg;
        best_row_next  = best_row_reg;
        best_col_next  = best_col_reg;
        bad_seen_next  = bad_seen_reg;
        if (work_go)
        begin
            if (work_item_reg.frame_end)
            begin
                best_size_next = '0;
                best_row_next  = '0;
                best_col_next  = '0;
                bad_seen_next  = 1'b0;
            end
            else
            begin
                if (better)
                begin
                    best_size_next = side;
                    best_row_next  = work_item_reg.row;
                    best_col_next  = work_item_reg.col;
                end
                bad_seen_next = bad_seen_reg || is_bad;
            end
        end

        out_valid_next = out_valid_reg;
        if (work_go && work_item_reg.frame_end)
            out_valid_next = 1'b1;
        else if (!result_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (work_go)
            line_buf[work_item_reg.col] <= side;
        if (pop)
            up_rd_reg <= line_buf[head_item.col];
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            work_item_reg <= head_item;
            fwd_val_reg   <= side;
        end
        if (work_go)
        begin
            left_reg <= side;
            diag_reg <= up;
        end
        if (work_go && work_item_reg.frame_end)
        begin
            out_size_reg <= better ? side : best_size_reg;
            out_row_reg  <= better ? work_item_reg.row : best_row_reg;
            out_col_reg  <= better ? work_item_reg.col : best_col_reg;
            out_bad_reg  <= bad_seen_reg || is_bad;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_valid_reg <= 1'b0;
            fwd_hit_reg    <= 1'b0;
            best_size_reg  <= '0;
            best_row_reg   <= '0;
            best_col_reg   <= '0;
            bad_seen_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            work_valid_reg <= work_valid_next;
            if (pop)
                fwd_hit_reg <= work_go && (work_item_reg.col == head_item.col);
            best_size_reg  <= best_size_next;
            best_row_reg   <= best_row_next;
            best_col_reg   <= best_col_next;
            bad_seen_reg   <= bad_seen_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign square_size  = out_size_reg;
    assign bottom_row   = out_row_reg;
    assign right_col    = out_col_reg;
    assign bad_cell     = out_bad_reg;

endmodule
`default_nettype wire

[rtl/largest_empty_square_finder.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// largest_empty_square_finder: largest all-empty square in a character grid
// Cells arrive in raster order; one result per frame on its last cell.
// ============================================================================
//
//   Channel   Direction  Handshake                Payload
//   cell      in         cell_valid / cell_stall  cell_char
//   result    out        result_valid / result_stall
//                                                 square_size, bottom_row,
//                                                 right_col, bad_cell
//   cfg       in         cfg_write                cfg_index, cfg_data
//
// One cell per clock cycle sustained while the queue has room. An accepted
// cell passes through the queue register into the back part's work register;
// the frame result is then registered at the output, limited by the
// line-buffer read and the recurrence stage. A four-entry queue separates
// the parts, so a stalled result blocks intake only once the queue fills.
// Reset clears all control state; the line buffer needs no clearing pass.
// ============================================================================
module largest_empty_square_finder (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [lesf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lesf_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            cell_valid,
    output logic                                 cell_stall,
    input  wire logic [lesf_pkg::CHAR_W-1:0]     cell_char,
    output logic                                 result_valid,
    input  wire logic                            result_stall,
    output logic [lesf_pkg::SIZE_W-1:0]          square_size,
    output logic [lesf_pkg::ROW_W-1:0]           bottom_row,
    output logic [lesf_pkg::COL_W-1:0]           right_col,
    output logic                                 bad_cell
);

    logic                 queue_full;
    logic                 push;
    lesf_pkg::cell_item_t push_item;
    logic                 pop;
    logic                 head_valid;
    lesf_pkg::cell_item_t head_item;

    lesf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cell_valid (cell_valid),
        .cell_char  (cell_char),
        .cell_stall (cell_stall),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    lesf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    lesf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_item    (head_item),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .square_size  (square_size),
        .bottom_row   (bottom_row),
        .right_col    (right_col),
        .bad_cell     (bad_cell)
    );

endmodule
`default_nettype wire

[rtl/lesf_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// lesf_checker: port-level checks of the largest empty square finder
// Watches the result channel for held transactions and for square geometry.
// ============================================================================
module lesf_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            result_valid,
    input  wire logic                            result_stall,
    input  wire logic [lesf_pkg::SIZE_W-1:0]     square_size,
    input  wire logic [lesf_pkg::ROW_W-1:0]      bottom_row,
    input  wire logic [lesf_pkg::COL_W-1:0]      right_col,
    input  wire logic                            bad_cell
);

    // A stalled result transaction stays offered and unchanged.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(square_size)
            && $stable(bottom_row) && $stable(right_col) && $stable(bad_cell))
        else $error("result changed while stalled");

    // With no empty cell the reported position stays at the origin.
    a_zero_origin: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (square_size == '0) |-> (bottom_row == '0) && (right_col == '0))
        else $error("nonzero position for an empty result");

    // The square must fit above and to the left of its bottom-right corner.
    a_square_fits: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
            ((lesf_pkg::SIZE_W'(bottom_row) + lesf_pkg::SIZE_W'(1)) >= square_size)
            && ((lesf_pkg::SIZE_W'(right_col) + lesf_pkg::SIZE_W'(1)) >= square_size))
        else $error("square does not fit at its corner");

    a_square_max: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> square_size <= lesf_pkg::SIZE_W'(lesf_pkg::MAX_ROWS))
        else $error("square larger than the grid");

endmodule

bind largest_empty_square_finder lesf_checker u_lesf_checker (.*);
`default_nettype wire

[verif/lesf_square_monitor.sv]
`timescale 1ns / 1ps
// ============================================================================
// lesf_square_monitor: prediction and comparison for the square finder
// Watches the configuration, cell and result channels. It keeps its own copy
// of the registers and of the scan state, predicts the frame results from the
// accepted cells, and compares every accepted result field by field.
// ============================================================================
module lesf_square_monitor (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [lesf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lesf_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            cell_valid,
    input  wire logic                            cell_stall,
    input  wire logic [lesf_pkg::CHAR_W-1:0]     cell_char,
    input  wire logic                            result_valid,
    input  wire logic                            result_stall,
    input  wire logic [lesf_pkg::SIZE_W-1:0]     square_size,
    input  wire logic [lesf_pkg::ROW_W-1:0]      bottom_row,
    input  wire logic [lesf_pkg::COL_W-1:0]      right_col,
    input  wire logic                            bad_cell,
    output int                                   mismatches,
    output int                                   outstanding
);

    localparam int unsigned SIDE_CEILING = 2047;

    typedef struct packed {
        logic [lesf_pkg::SIZE_W-1:0] side;
        logic [lesf_pkg::ROW_W-1:0]  row;
        logic [lesf_pkg::COL_W-1:0]  col;
        logic                        bad;
    } square_t;

    logic [lesf_pkg::COUNT_W-1:0] row_count_q;
    logic [lesf_pkg::COUNT_W-1:0] col_count_q;
    logic [lesf_pkg::CHAR_W-1:0]  empty_q;
    logic [lesf_pkg::CHAR_W-1:0]  obstacle_q;

    int unsigned line_sides [lesf_pkg::MAX_COLS];
    int unsigned left_side;
    int unsigned diag_side;
    int unsigned scan_row;
    int unsigned scan_col;
    int unsigned best_side;
    int unsigned best_row;
    int unsigned best_col;
    logic        bad_seen;

    square_t expected_squares [$];

    function automatic int unsigned dim_limit(input int unsigned v, input int unsigned ceiling);
        if (v == 0)
            return 1;
        if (v > ceiling)
            return ceiling;
        return v;
    endfunction

    task automatic clear_frame();
        left_side = 0;
        diag_side = 0;
        scan_row  = 0;
        scan_col  = 0;
        best_side = 0;
        best_row  = 0;
        best_col  = 0;
        bad_seen  = 1'b0;
    endtask

    // One step of the maximal-square recurrence; queues the frame result on its
    // last cell.
    task automatic advance_square_scan(input logic [lesf_pkg::CHAR_W-1:0] ch);
        int unsigned rows;
        int unsigned cols;
        int unsigned up;
        int unsigned side;
        square_t     found;
        rows = dim_limit(row_count_q, lesf_pkg::MAX_ROWS);
        cols = dim_limit(col_count_q, lesf_pkg::MAX_COLS);
        up   = line_sides[scan_col];
        if (ch == obstacle_q)
        begin
            side = 0;
        end
        else if (ch != empty_q)
        begin
            side     = 0;
            bad_seen = 1'b1;
        end
        else if (scan_row == 0 || scan_col == 0)
        begin
            side = 1;
        end
        else
        begin
            side = (up < left_side) ? up : left_side;
            if (diag_side < side)
                side = diag_side;
            side = side + 1;
            if (side > SIDE_CEILING)
                side = SIDE_CEILING;
        end

        // Strictly greater keeps the first position in raster order on a tie.
        if (side > best_side)
        begin
            best_side = side;
            best_row  = scan_row;
            best_col  = scan_col;
        end

        line_sides[scan_col] = side;
        diag_side = up;
        left_side = side;

        if (scan_col + 1 < cols)
        begin
            scan_col = scan_col + 1;
        end
        else
        begin
            scan_col  = 0;
            left_side = 0;
            diag_side = 0;
            if (scan_row + 1 < rows)
            begin
                scan_row = scan_row + 1;
            end
            else
            begin
                found.side = lesf_pkg::SIZE_W'(best_side);
                found.row  = lesf_pkg::ROW_W'(best_row);
                found.col  = lesf_pkg::COL_W'(best_col);
                found.bad  = bad_seen;
                expected_squares.push_back(found);
                clear_frame();
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        square_t want;
        if (!rst_n)
        begin
            row_count_q = lesf_pkg::ROW_COUNT_RST;
            col_count_q = lesf_pkg::COL_COUNT_RST;
            empty_q     = lesf_pkg::EMPTY_CHAR_RST;
            obstacle_q  = lesf_pkg::OBST_CHAR_RST;
            foreach (line_sides[i])
                line_sides[i] = 0;
            clear_frame();
            expected_squares.delete();
            mismatches = 0;
        end
        else
        begin
            // A result accepted at this edge belongs to earlier cells, so it is
            // matched before the cell of this edge is predicted.
            if (result_valid && !result_stall)
            begin
                if (expected_squares.size() == 0)
                begin
                    $error("unexpected result transaction: size %0d row %0d col %0d bad %0d",
                           square_size, bottom_row, right_col, bad_cell);
                    mismatches++;
                end
                else
                begin
                    want = expected_squares.pop_front();
                    if (square_size !== want.side)
                    begin
                        $error("square_size: expected %0d, actual %0d", want.side, square_size);
                        mismatches++;
                    end
                    if (bottom_row !== want.row)
                    begin
                        $error("bottom_row: expected %0d, actual %0d", want.row, bottom_row);
                        mismatches++;
                    end
                    if (right_col !== want.col)
                    begin
                        $error("right_col: expected %0d, actual %0d", want.col, right_col);
                        mismatches++;
                    end
                    if (bad_cell !== want.bad)
                    begin
                        $error("bad_cell: expected %0d, actual %0d", want.bad, bad_cell);
                        mismatches++;
                    end
                end
            end

            // A cell accepted at the same edge as a register write still sees
            // the register values from before the write.
            if (cell_valid && !cell_stall)
                advance_square_scan(cell_char);

            if (cfg_write)
            begin
                case (lesf_pkg::cfg_reg_t'(cfg_index))
                    lesf_pkg::REG_ROW_COUNT:     row_count_q = cfg_data;
                    lesf_pkg::REG_COLUMN_COUNT:  col_count_q = cfg_data;
                    lesf_pkg::REG_EMPTY_CHAR:    empty_q     = cfg_data[lesf_pkg::CHAR_W-1:0];
                    lesf_pkg::REG_OBSTACLE_CHAR: obstacle_q  = cfg_data[lesf_pkg::CHAR_W-1:0];
                    default: ;
                endcase
            end
        end
        outstanding = expected_squares.size();
    end

endmodule

[verif/largest_empty_square_finder_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// largest_empty_square_finder_tb: regression for the largest empty square finder
// Drives character grids frame by frame under changing dimensions and cell
// codes, with random gaps on the cell side and random stalls on the result
// side. The monitor predicts and checks; this module gives the verdict.
// ============================================================================
module largest_empty_square_finder_tb;

    localparam int STALL_PCT      = 23;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TARGET_CELLS   = 1900;
    localparam int MIN_FRAMES     = 16;
    localparam int SETTLE_CYCLES  = 4;
    localparam int SMALL_AREA     = 36;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_write;
    logic [lesf_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [lesf_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                            cell_valid;
    logic                            cell_stall;
    logic [lesf_pkg::CHAR_W-1:0]     cell_char;
    logic                            result_valid;
    logic                            result_stall;
    logic [lesf_pkg::SIZE_W-1:0]     square_size;
    logic [lesf_pkg::ROW_W-1:0]      bottom_row;
    logic [lesf_pkg::COL_W-1:0]      right_col;
    logic                            bad_cell;

    int mismatches;
    int outstanding;
    int idle_cycles = 0;
    int cells_sent  = 0;
    int frames_done = 0;
    bit quiet       = 1'b0;

    int unsigned                 frame_rows = 1;
    int unsigned                 frame_cols = 1;
    logic [lesf_pkg::CHAR_W-1:0] empty_code    = lesf_pkg::EMPTY_CHAR_RST;
    logic [lesf_pkg::CHAR_W-1:0] obstacle_code = lesf_pkg::OBST_CHAR_RST;

    largest_empty_square_finder i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cell_valid   (cell_valid),
        .cell_stall   (cell_stall),
        .cell_char    (cell_char),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .square_size  (square_size),
        .bottom_row   (bottom_row),
        .right_col    (right_col),
        .bad_cell     (bad_cell)
    );

    lesf_square_monitor i_monitor (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cell_valid   (cell_valid),
        .cell_stall   (cell_stall),
        .cell_char    (cell_char),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .square_size  (square_size),
        .bottom_row   (bottom_row),
        .right_col    (right_col),
        .bad_cell     (bad_cell),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(negedge clk)
    begin
        result_stall <= !quiet && ($urandom_range(0, 99) < STALL_PCT);
    end

    // Ends the run if no transaction moves on either channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (cell_valid && !cell_stall) || (result_valid && !result_stall))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int unsigned dim_of(input int unsigned v, input int unsigned ceiling);
        return (v == 0) ? 1 : ((v > ceiling) ? ceiling : v);
    endfunction

    function automatic logic [lesf_pkg::CHAR_W-1:0] stray_code();
        logic [lesf_pkg::CHAR_W-1:0] ch;
        do
            ch = lesf_pkg::CHAR_W'($urandom_range(0, 255));
        while (ch == empty_code || ch == obstacle_code);
        return ch;
    endfunction

    function automatic logic [lesf_pkg::CHAR_W-1:0] pick_code();
        int unsigned r;
        r = $urandom_range(0, 3);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return lesf_pkg::CHAR_W'($urandom_range(0, 255));
    endfunction

    function automatic int unsigned small_dim();
        return ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 6);
    endfunction

    // The write enable is left high between back-to-back writes and lowered
    // once by the caller.
    task automatic write_reg(input lesf_pkg::cfg_reg_t idx,
                             input logic [lesf_pkg::CFG_DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
    endtask

    task automatic set_grid(input int unsigned rows_val, input int unsigned cols_val);
        write_reg(lesf_pkg::REG_ROW_COUNT, lesf_pkg::CFG_DATA_W'(rows_val));
        write_reg(lesf_pkg::REG_COLUMN_COUNT, lesf_pkg::CFG_DATA_W'(cols_val));
        cfg_write <= 1'b0;
        @(negedge clk);
        frame_rows = dim_of(rows_val, lesf_pkg::MAX_ROWS);
        frame_cols = dim_of(cols_val, lesf_pkg::MAX_COLS);
    endtask

    // Upper data bits above the character width are random and must be ignored.
    task automatic set_codes(input logic [lesf_pkg::CHAR_W-1:0] e,
                             input logic [lesf_pkg::CHAR_W-1:0] o);
        write_reg(lesf_pkg::REG_EMPTY_CHAR, {3'($urandom_range(0, 7)), e});
        write_reg(lesf_pkg::REG_OBSTACLE_CHAR, {3'($urandom_range(0, 7)), o});
        cfg_write <= 1'b0;
        @(negedge clk);
        empty_code    = e;
        obstacle_code = o;
    endtask

    // Returns at the falling edge after acceptance with valid still high, so
    // consecutive cells need no extra assignment to the valid.
    task automatic send_cell(input logic [lesf_pkg::CHAR_W-1:0] ch);
        while (!quiet && $urandom_range(0, 99) < STALL_PCT)
        begin
            cell_valid <= 1'b0;
            @(negedge clk);
        end
        cell_valid <= 1'b1;
        cell_char  <= ch;
        @(posedge clk);
        while (cell_stall)
            @(posedge clk);
        @(negedge clk);
        cells_sent++;
    endtask

    task automatic finish_frame();
        cell_valid <= 1'b0;
        frames_done++;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic send_frame(input int empty_pct, input int bad_pct, input int lead);
        int unsigned                 n;
        int unsigned                 r;
        logic [lesf_pkg::CHAR_W-1:0] ch;
        n = frame_rows * frame_cols;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (i < lead)
                ch = obstacle_code;
            else if (r < empty_pct)
                ch = empty_code;
            else if (r < empty_pct + bad_pct)
                ch = stray_code();
            else
                ch = obstacle_code;
            send_cell(ch);
        end
        finish_frame();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = lesf_pkg::REG_ROW_COUNT;
        cfg_data     = '0;
        cell_valid   = 1'b0;
        cell_char    = '0;
        result_stall = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings give one-cell frames: empty, obstacle, stray character.
        send_cell(lesf_pkg::EMPTY_CHAR_RST);
        send_cell(lesf_pkg::OBST_CHAR_RST);
        send_cell(8'h58);
        finish_frame();

        // Fully empty 3x3 grid grows to a square of side three.
        set_grid(3, 3);
        repeat (9) send_cell(lesf_pkg::EMPTY_CHAR_RST);
        finish_frame();

        // Zero counts act as one; with equal codes a matching cell is an obstacle.
        set_grid(0, 0);
        set_codes(8'h41, 8'h41);
        send_cell(8'h41);
        send_cell(8'h2E);
        finish_frame();

        // Extreme codes, a tie of side two and a stray cell at the row end.
        set_grid(2, 4);
        set_codes(8'h00, 8'hFF);
        send_cell(8'h00);
        send_cell(8'h00);
        send_cell(8'h00);
        send_cell(8'hFF);
        send_cell(8'h00);
        send_cell(8'h00);
        send_cell(8'h00);
        send_cell(8'h80);
        finish_frame();

        frames_done = 0;
        for (int k = 0; !(k > 15 && cells_sent >= TARGET_CELLS && frames_done >= MIN_FRAMES);
             k++)
        begin
            quiet <= (k >= 6 && k <= 10);
            case (k)
                3:
                begin
                    // Oversize column count with a zero row count: one row of 1024.
                    set_grid(0, 2047);
                    set_codes(8'hFF, 8'h00);
                    send_frame(90, 3, $urandom_range(520, 1000));
                end
                9:
                begin
                    // A tall single-column grid; every cell reads its own column.
                    set_grid(640, 1);
                    set_codes(8'h00, 8'hFF);
                    send_frame(85, 3, $urandom_range(300, 600));
                end
                15:
                begin
                    set_grid(8, 8);
                    set_codes(8'h2E, 8'h23);
                    send_frame(95, 1, 0);
                end
                default:
                begin
                    // Large grids left over from the directed frames are replaced.
                    if ($urandom_range(0, 1) == 1 || frame_rows * frame_cols > SMALL_AREA)
                        set_grid(small_dim(), small_dim());
                    if ($urandom_range(0, 2) == 0)
                    begin
                        empty_code = pick_code();
                        set_codes(empty_code,
                                  ($urandom_range(0, 7) == 0) ? empty_code : pick_code());
                    end
                    send_frame(70, 8, 0);
                end
            endcase
        end

        if (mismatches == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[filelist.f]
rtl/lesf_pkg.sv
rtl/lesf_front.sv
rtl/lesf_queue.sv
rtl/lesf_back.sv
rtl/largest_empty_square_finder.sv
rtl/lesf_checker.sv
verif/lesf_square_monitor.sv
verif/largest_empty_square_finder_tb.sv
